### rtl/core/sml_pkg.sv
// sml_pkg: shared types and constants of the sorted list merge block
// no dependencies; imported by every module under rtl/core
package sml_pkg;

    localparam int DATA_W          = 32;
    localparam int CNT_W           = 6;
    localparam int CFG_IDX_W       = 1;
    localparam int LIST_DEPTH_DEF  = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SECOND = 1'b1;

    typedef struct packed {
        logic                     list_sel;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] merged_value;
        logic                     from_second;
        logic                     last;
    } t_out_item;

endpackage

### rtl/core/sml_buf.sv
// sml_buf: one list buffer, single write port, registered read port
// uses sml_pkg for the data width
module sml_buf
    import sml_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    parameter int AW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/sml_seq.sv
// sml_seq: load sequencer and merge walker over the two list buffers
// uses sml_pkg item types; drives the buffer ports and the output register
module sml_seq
    import sml_pkg::*;
#(
    parameter int AW = 5,
    parameter int FW = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  t_in_item                 i_in_item,
    output logic                     o_in_stall,
    input  logic [FW-1:0]            i_n1,
    input  logic [FW-1:0]            i_n2,
    output logic                     o_wr_en1,
    output logic                     o_wr_en2,
    output logic [AW-1:0]            o_wr_addr,
    output logic [AW-1:0]            o_rd_addr1,
    output logic [AW-1:0]            o_rd_addr2,
    input  logic signed [DATA_W-1:0] i_rd_data1,
    input  logic signed [DATA_W-1:0] i_rd_data2,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_item
);

    typedef enum logic [1:0] {S_LOAD, S_PRIME, S_MERGE} t_state;

    t_state         r_state;
    logic [FW-1:0]  r_f1, r_f2, r_i, r_j;
    logic           r_out_valid;
    t_out_item      r_out_item;

    logic           in_acc, out_free, pick, take1, full, last;
    logic [FW-1:0]  f1_nx, f2_nx, n_i, n_j;
    logic [FW:0]    total;

    always_comb begin
        in_acc   = i_in_valid && (r_state == S_LOAD);
        o_wr_en1 = in_acc && !i_in_item.list_sel && (r_f1 < i_n1);
        o_wr_en2 = in_acc &&  i_in_item.list_sel && (r_f2 < i_n2);
        o_wr_addr = i_in_item.list_sel ? r_f2[AW-1:0] : r_f1[AW-1:0];
        f1_nx    = r_f1 + FW'(o_wr_en1);
        f2_nx    = r_f2 + FW'(o_wr_en2);
        full     = (f1_nx >= i_n1) && (f2_nx >= i_n2);
        total    = {1'b0, i_n1} + {1'b0, i_n2};

        // ties go to the second list
        out_free = !r_out_valid || !i_out_stall;
        take1    = (r_i < i_n1) && ((r_j >= i_n2) || (i_rd_data1 < i_rd_data2));
        pick     = (r_state == S_MERGE) && out_free;
        n_i      = r_i + FW'(pick && take1);
        n_j      = r_j + FW'(pick && !take1);
        last     = (({1'b0, r_i} + {1'b0, r_j} + (FW+1)'(1)) == total);

        // read the next head each cycle so the registered buffer read has it ready in the next cycle
        o_rd_addr1 = n_i[AW-1:0];
        o_rd_addr2 = n_j[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_f1        <= '0;
            r_f2        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_f1 <= full ? '0 : f1_nx;
                        r_f2 <= full ? '0 : f2_nx;
                        if (full) begin
                            r_i  <= '0;
                            r_j  <= '0;
                            if (total != '0) begin
                                r_state <= S_PRIME;
                            end
                        end
                    end
                end
                S_PRIME: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (pick) begin
                        r_out_item.merged_value <= take1 ? i_rd_data1 : i_rd_data2;
                        r_out_item.from_second  <= !take1;
                        r_out_item.last         <= last;
                        r_i                     <= n_i;
                        r_j                     <= n_j;
                        if (last) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/core/sorted_list_merge_top.sv
// sorted_list_merge_top: count registers, two list buffers and the merge sequencer
// uses sml_pkg, sml_buf and sml_seq
//
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_stall   i_in_item  (t_in_item)
//   out       output      o_out_valid / i_out_stall o_out_item (t_out_item)
//   cfg       input       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// loading takes one item per cycle, one buffer write each while its list is not yet full
// the item that fills both lists is followed by the S_PRIME state to read both heads,
// then n1 + n2 results at one per cycle unless the output stalls, paced by the registered buffer reads
// the input is stalled after that item until the last result is registered
// synchronous active-low reset clears the counts, fills, merge indexes, state and output valid
module sorted_list_merge_top
    import sml_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FW = $clog2(LIST_DEPTH + 1);

    logic [CNT_W-1:0]         r_count_first, r_count_second;
    logic [FW-1:0]            n1, n2;
    logic                     wr_en1, wr_en2;
    logic [AW-1:0]            wr_addr, rd_addr1, rd_addr2;
    logic signed [DATA_W-1:0] rd_data1, rd_data2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_first  <= '0;
            r_count_second <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COUNT_FIRST:  r_count_first  <= i_cfg_data;
                CFG_COUNT_SECOND: r_count_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // counts above the buffer depth act as the depth
    assign n1 = (r_count_first  > CNT_W'(LIST_DEPTH)) ? FW'(LIST_DEPTH)
                                                     : r_count_first[FW-1:0];
    assign n2 = (r_count_second > CNT_W'(LIST_DEPTH)) ? FW'(LIST_DEPTH)
                                                     : r_count_second[FW-1:0];

    sml_buf #(.DEPTH(LIST_DEPTH), .AW(AW)) u_buf_first (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en1),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_item.value),
        .i_rd_addr (rd_addr1),
        .o_rd_data (rd_data1)
    );

    sml_buf #(.DEPTH(LIST_DEPTH), .AW(AW)) u_buf_second (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en2),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_item.value),
        .i_rd_addr (rd_addr2),
        .o_rd_data (rd_data2)
    );

    sml_seq #(.AW(AW), .FW(FW)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_n1        (n1),
        .i_n2        (n2),
        .o_wr_en1    (wr_en1),
        .o_wr_en2    (wr_en2),
        .o_wr_addr   (wr_addr),
        .o_rd_addr1  (rd_addr1),
        .o_rd_addr2  (rd_addr2),
        .i_rd_data1  (rd_data1),
        .i_rd_data2  (rd_data2),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
